FILE: sv/bsa_pkg.sv
// bsa_pkg: shared constants, codes and types of the bitmap slot allocator.
// No dependencies; compiled first.
`default_nettype none

package bsa_pkg;

  // geometry of the taken map
  localparam int SLOTS   = 256;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CAP_W   = SLOT_W + 1;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int NWORDS  = SLOTS / WORD_W;
  localparam int WIDX_W  = $clog2(NWORDS);

  // config port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(SLOTS);
  localparam logic [CAP_W-1:0] INIT_RESET = '0;

  typedef enum logic [1:0] {
    FN_ALLOC  = 2'd0,
    FN_FREE   = 2'd1,
    FN_MARK   = 2'd2,
    FN_REINIT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_TAKEN = 2'd3
  } status_t;

  typedef enum logic {
    REG_CAPACITY   = 1'b0,
    REG_INIT_TAKEN = 1'b1
  } reg_t;

  // one access to the map memory
  typedef struct packed {
    logic              rd_en;
    logic [WIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [WIDX_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } map_req_t;

endpackage

`default_nettype wire

FILE: sv/bsa_if.sv
// bsa_if: request and response channel interfaces of the slot allocator.
// Depends on bsa_pkg.
`default_nettype none

interface bsa_req_if;
  import bsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [SLOT_W-1:0] slot_index;
  logic [CAP_W-1:0]  count;
  modport source(output valid, func, slot_index, count, input ready);
  modport sink(input valid, func, slot_index, count, output ready);
endinterface

interface bsa_rsp_if;
  import bsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] granted_index;
  logic [1:0]        status;
  modport source(output valid, granted_index, status, input ready);
  modport sink(input valid, granted_index, status, output ready);
endinterface

`default_nettype wire

FILE: sv/bitmap_slot_allocator.sv
// bitmap_slot_allocator: first-fit slot allocator over a bitmap of taken slots.
// Top level: APB config registers, operation sequencer, result register.
// Depends on bsa_pkg, bsa_if, bsa_map.
//
// Usage:
//  - req channel (valid/ready) carries one operation per beat: func, slot_index,
//    count. rsp channel returns exactly one beat per request: granted_index,
//    status. Results leave in request order.
//  - The map lives in an 8 x 32-bit RAM (registered read). The sequencer does
//    read-modify-write on it, one word per cycle, reads pipelined ahead of
//    the word being checked or written.
//  - Per operation: allocate scans words from word 0 up to a free bit or the
//    end of capacity; free reads and checks one word; mark range does
//    read-modify-write on each word touched; reinitialize rewrites all 8
//    words. Rejected operations (out of capacity) and zero-count marks skip
//    the map. The word-serial RAM access sets the rate: a new request is
//    only taken after the previous operation has finished.
//  - A new request is taken once the previous result is in the output
//    register, even if rsp is stalled. A finished result waits in the
//    sequencer while the output register still holds an untaken beat.
//  - Reset (rst, synchronous) empties the map (no slot taken), sets capacity
//    to 256 and initially_taken to 0. Config writes are taken any time but
//    are meant to happen only while the block is idle.
`default_nettype none

module bitmap_slot_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst,
  bsa_req_if.sink                         req,
  bsa_rsp_if.source                       rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bsa_pkg::APB_AW-1:0] paddr,
  input  wire logic [bsa_pkg::APB_DW-1:0] pwdata,
  output logic      [bsa_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import bsa_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN     = 7'b0000010,
    S_FREE_RD  = 7'b0000100,
    S_FREE_CHK = 7'b0001000,
    S_SWEEP    = 7'b0010000,
    S_INIT     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  // number of slots of word w that lie below lim, 0..WORD_W
  function automatic logic [BIT_W:0] span(input logic [CAP_W:0] lim,
                                          input logic [WIDX_W-1:0] w);
    logic [CAP_W:0] base;
    logic [CAP_W:0] diff;
    base = (CAP_W+1)'({w, {BIT_W{1'b0}}});
    diff = lim - base;
    if (lim <= base) begin
      return '0;
    end else if (diff >= (CAP_W+1)'(WORD_W)) begin
      return (BIT_W+1)'(WORD_W);
    end else begin
      return diff[BIT_W:0];
    end
  endfunction

  // ones in bits below n
  function automatic logic [WORD_W-1:0] lo_mask(input logic [BIT_W:0] n);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = ((BIT_W+1)'(i) < n);
    end
    return m;
  endfunction

  // lowest set bit
  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] f;
    f = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) f = BIT_W'(i);
    end
    return f;
  endfunction

  // ---------------- config registers ----------------
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] init_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      init_taken <= INIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_t'(paddr[2]))
        REG_CAPACITY:   capacity   <= pwdata[CAP_W-1:0];
        REG_INIT_TAKEN: init_taken <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_t'(paddr[2]))
      REG_CAPACITY:   prdata = APB_DW'(capacity);
      REG_INIT_TAKEN: prdata = APB_DW'(init_taken);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // effective capacity and reinit fill level
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] ninit;
  assign cap   = (capacity > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : capacity;
  assign ninit = (init_taken < cap) ? init_taken : cap;

  // ---------------- sequencer ----------------
  state_t             state, state_next;
  logic [WIDX_W-1:0]  rd_ptr, rd_ptr_next;
  logic [WIDX_W-1:0]  chk_ptr;        // word whose data is on rd_data
  logic               chk_vld;
  logic [SLOT_W-1:0]  idx_q;
  logic [CAP_W:0]     end_q;          // slot_index + count
  logic [WIDX_W-1:0]  last_w, last_w_next;
  logic [SLOT_W-1:0]  res_idx, res_idx_next;
  status_t            res_st, res_st_next;

  logic               out_valid;
  logic [SLOT_W-1:0]  out_index;
  status_t            out_status;
  logic               out_free;

  map_req_t           mreq;
  logic [WORD_W-1:0]  rd_data;

  logic               req_acc;
  logic [CAP_W:0]     req_end;
  logic [CAP_W:0]     req_end_m1;
  logic [WORD_W-1:0]  free_bits;
  logic               alloc_last;
  logic [WORD_W-1:0]  mark_mask;

  assign req.ready  = (state == S_IDLE);
  assign req_acc    = req.valid && req.ready;
  assign req_end    = (CAP_W+1)'(req.slot_index) + (CAP_W+1)'(req.count);
  assign req_end_m1 = req_end - (CAP_W+1)'(1);
  assign out_free   = !out_valid || rsp.ready;

  // free slots of the checked word below capacity
  assign free_bits  = ~rd_data & lo_mask(span((CAP_W+1)'(cap), chk_ptr));
  assign alloc_last = (chk_ptr == WIDX_W'(NWORDS - 1)) ||
                      (span((CAP_W+1)'(cap), chk_ptr) != (BIT_W+1)'(WORD_W));
  assign mark_mask  = lo_mask(span(end_q, chk_ptr)) &
                      ~lo_mask(span((CAP_W+1)'(idx_q), chk_ptr));

  always_comb begin
    state_next   = state;
    rd_ptr_next  = rd_ptr;
    last_w_next  = last_w;
    res_idx_next = res_idx;
    res_st_next  = res_st;
    mreq         = '0;
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          res_idx_next = '0;
          res_st_next  = ST_OK;
          rd_ptr_next  = '0;
          case (func_t'(req.func))
            FN_ALLOC: begin
              if (cap == '0) begin
                res_st_next = ST_FULL;
                state_next  = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            FN_FREE: begin
              if (CAP_W'(req.slot_index) >= cap) begin
                res_st_next = ST_RANGE;
                state_next  = S_DONE;
              end else begin
                state_next = S_FREE_RD;
              end
            end
            FN_MARK: begin
              if (req_end > (CAP_W+1)'(cap)) begin
                res_st_next = ST_RANGE;
                state_next  = S_DONE;
              end else if (req.count == '0) begin
                state_next = S_DONE;
              end else begin
                rd_ptr_next = req.slot_index[SLOT_W-1:BIT_W];
                last_w_next = req_end_m1[SLOT_W-1:BIT_W];
                state_next  = S_SWEEP;
              end
            end
            FN_REINIT: begin
              state_next = S_INIT;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = rd_ptr;
        rd_ptr_next  = rd_ptr + WIDX_W'(1);
        if (chk_vld) begin
          if (|free_bits) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = chk_ptr;
            mreq.wr_data = rd_data | (WORD_W'(1) << first_one(free_bits));
            res_idx_next = {chk_ptr, first_one(free_bits)};
            res_st_next  = ST_OK;
            state_next   = S_DONE;
          end else if (alloc_last) begin
            res_st_next = ST_FULL;
            state_next  = S_DONE;
          end
        end
      end
      S_FREE_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = idx_q[SLOT_W-1:BIT_W];
        state_next   = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (rd_data[idx_q[BIT_W-1:0]]) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = idx_q[SLOT_W-1:BIT_W];
          mreq.wr_data = rd_data & ~(WORD_W'(1) << idx_q[BIT_W-1:0]);
        end else begin
          res_st_next = ST_NOT_TAKEN;
        end
        state_next = S_DONE;
      end
      S_SWEEP: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = rd_ptr;
        rd_ptr_next  = rd_ptr + WIDX_W'(1);
        if (chk_vld) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = chk_ptr;
          mreq.wr_data = rd_data | mark_mask;
          if (chk_ptr == last_w) state_next = S_DONE;
        end
      end
      S_INIT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = rd_ptr;
        mreq.wr_data = lo_mask(span((CAP_W+1)'(ninit), rd_ptr));
        rd_ptr_next  = rd_ptr + WIDX_W'(1);
        if (rd_ptr == WIDX_W'(NWORDS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      chk_vld <= 1'b0;
    end else begin
      state   <= state_next;
      // data on rd_data next cycle belongs to this op only if it continues
      chk_vld <= mreq.rd_en && (state_next == state);
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr  <= rd_ptr_next;
    chk_ptr <= rd_ptr;
    last_w  <= last_w_next;
    res_idx <= res_idx_next;
    res_st  <= res_st_next;
    if (req_acc) begin
      idx_q <= req.slot_index;
      end_q <= req_end;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_index  <= res_idx;
      out_status <= res_st;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.granted_index = out_index;
  assign rsp.status        = out_status;

  bsa_map u_map (
    .clk     (clk),
    .rst     (rst),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("accepted request did not start an operation");

  a_alloc_sets_one: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && mreq.wr_en |->
      $countones(mreq.wr_data) == $countones(rd_data) + 1)
    else $error("allocate wrote more or less than one new taken bit");

  a_free_clears_one: assert property (@(posedge clk) disable iff (rst)
    state == S_FREE_CHK && mreq.wr_en |->
      $countones(mreq.wr_data) + 1 == $countones(rd_data))
    else $error("free cleared more or less than one taken bit");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !rsp.ready |=> state == S_DONE)
    else $error("result dropped while output register busy");
`endif

endmodule

`default_nettype wire

FILE: sv/bsa_map.sv
// bsa_map: taken-bit store, NWORDS x WORD_W synchronous RAM, registered read.
// Per-row valid flops make unwritten rows read as all free after reset.
// Depends on bsa_pkg.
`default_nettype none

module bsa_map (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bsa_pkg::map_req_t mreq,
  output logic [bsa_pkg::WORD_W-1:0] rd_data
);
  import bsa_pkg::*;

  logic [WORD_W-1:0] mem [NWORDS];
  logic [NWORDS-1:0] row_valid;
  logic [WORD_W-1:0] rd_q;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rd_q   <= mem[mreq.rd_addr];
      rd_vld <= row_valid[mreq.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mreq.wr_en) begin
      row_valid[mreq.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

`ifndef NO_ASSERTIONS
  // sequencer never reads a row in the cycle it writes it
  a_no_rw_same_row: assert property (@(posedge clk) disable iff (rst)
    mreq.rd_en && mreq.wr_en |-> mreq.rd_addr != mreq.wr_addr)
    else $error("map read and write hit the same row");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    mreq.wr_en |=> row_valid[$past(mreq.wr_addr)])
    else $error("written row not marked valid");
`endif

endmodule

`default_nettype wire

FILE: bench/bsa_checker.sv
// bsa_checker: watches the request, response and config ports of the slot allocator,
// predicts each result from its own copy of the taken map and compares field by field.
// Depends on bsa_pkg and bsa_if.
module bsa_checker (
  input  logic                       clk,
  input  logic                       rst,
  bsa_req_if                         req,
  bsa_rsp_if                         rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsa_pkg::APB_AW-1:0] paddr,
  input  logic [bsa_pkg::APB_DW-1:0] pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         outstanding
);
  import bsa_pkg::*;

  typedef struct {
    logic [SLOT_W-1:0] granted_index;
    status_t           status;
  } slot_result_t;

  logic [SLOTS-1:0]  taken_map;
  logic [CAP_W-1:0]  capacity_reg;
  logic [CAP_W-1:0]  init_taken_reg;
  slot_result_t      result_q[$];

  // model of every operation (first-fit allocate, free, mark, reinit), updates taken_map as the block would
  function automatic slot_result_t apply_op(func_t f, logic [SLOT_W-1:0] idx,
                                            logic [CAP_W-1:0] cnt);
    slot_result_t r;
    int           live;
    int           n;
    bit           found;
    r.granted_index = '0;
    r.status        = ST_OK;
    live  = (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
    found = 1'b0;
    case (f)
      FN_ALLOC: begin
        r.status = ST_FULL;
        for (int i = 0; i < live; i++) begin
          if (!found && !taken_map[i]) begin
            found           = 1'b1;
            taken_map[i]    = 1'b1;
            r.granted_index = SLOT_W'(i);
            r.status        = ST_OK;
          end
        end
      end
      FN_FREE: begin
        if (int'(idx) >= live) r.status = ST_RANGE;
        else if (!taken_map[idx]) r.status = ST_NOT_TAKEN;
        else taken_map[idx] = 1'b0;
      end
      FN_MARK: begin
        if (int'(idx) + int'(cnt) > live) r.status = ST_RANGE;
        else for (int i = 0; i < int'(cnt); i++) taken_map[int'(idx) + i] = 1'b1;
      end
      default: begin
        n = (int'(init_taken_reg) < live) ? int'(init_taken_reg) : live;
        taken_map = '0;
        for (int i = 0; i < n; i++) taken_map[i] = 1'b1;
      end
    endcase
    return r;
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      taken_map      = '0;
      capacity_reg   = CAP_RESET;
      init_taken_reg = INIT_RESET;
      result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_t'(paddr[APB_AW-1:2]))
          REG_CAPACITY:   capacity_reg   = pwdata[CAP_W-1:0];
          REG_INIT_TAKEN: init_taken_reg = pwdata[CAP_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        result_q.push_back(apply_op(func_t'(req.func), req.slot_index, req.count));
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          $error("response beat with no request pending: granted_index %0d status %0d",
                 rsp.granted_index, rsp.status);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (rsp.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, got %0d", want.granted_index,
                   rsp.granted_index);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
        end
      end
    end
    outstanding = result_q.size();
  end

endmodule

FILE: bench/tb_top.sv
// tb_top: stimulus and verdict for the bitmap slot allocator.
// Depends on bsa_pkg, bsa_if, bitmap_slot_allocator and bsa_checker.
module tb_top;
  import bsa_pkg::*;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                outstanding;

  // sender gap and receiver stall odds, percent per cycle
  int send_gap_pct;
  int rcv_stall_pct;
  // long receiver hold-off, set at a rising edge, counted down at falling edges
  int hold_left;

  bsa_req_if req_ch();
  bsa_rsp_if rsp_ch();

  bitmap_slot_allocator u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch.sink),
    .rsp     (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bsa_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far above the slowest legal run (~1200 beats, each a block
  // operation plus long random gaps and stalls on both sides).
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Response side: random backpressure, or a long forced hold-off when asked.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // One request beat. Called and returns at a falling edge; valid stays up
  // across back-to-back beats unless a random gap drops it.
  task automatic issue(func_t f, logic [SLOT_W-1:0] idx, logic [CAP_W-1:0] cnt);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.slot_index <= idx;
    req_ch.count      <= cnt;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Stop sending and let every pending beat come back, plus slack for the
  // longest operation (a full allocate scan) before touching registers.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // APB write: setup then access; taken at the edge with penable and pready high.
  task automatic apb_write(reg_t r, logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(int cap, int init);
    settle();
    apb_write(REG_CAPACITY, APB_DW'(cap));
    apb_write(REG_INIT_TAKEN, APB_DW'(init));
  endtask

  // Mostly well-formed traffic aimed inside the live capacity, so frees stay
  // in range and ranges fit; a slice of raw noise over the full field range.
  task automatic random_op(int live);
    int r;
    int idx;
    int cnt;
    r = $urandom_range(99);
    if (r < 8 || live == 0) begin
      issue(func_t'($urandom_range(3)), SLOT_W'($urandom_range(255)),
            CAP_W'($urandom_range(511)));
    end else if (r < 50) begin
      issue(FN_ALLOC, SLOT_W'($urandom_range(255)), CAP_W'($urandom_range(511)));
    end else if (r < 78) begin
      issue(FN_FREE, SLOT_W'($urandom_range(live - 1)), CAP_W'($urandom_range(511)));
    end else if (r < 96) begin
      idx = $urandom_range(live - 1);
      cnt = $urandom_range((live - idx < 6) ? live - idx : 6);
      issue(FN_MARK, SLOT_W'(idx), CAP_W'(cnt));
    end else begin
      issue(FN_REINIT, SLOT_W'($urandom_range(255)), CAP_W'($urandom_range(511)));
    end
  endtask

  // One register setting and a burst of random beats under it. With stress
  // set, the receiver is held off long enough to back the block up, and the
  // sender later pauses until everything has drained.
  task automatic run_segment(int n_items, int cap, int init, bit stress);
    int live;
    live = (cap > SLOTS) ? SLOTS : cap;
    set_regs(cap, init);
    issue(FN_REINIT, '0, '0);
    for (int i = 0; i < n_items; i++) begin
      if (stress && i == 20) begin
        @(posedge clk);
        hold_left = 300;
        @(negedge clk);
      end
      if (stress && i == n_items / 2) settle();
      random_op(live);
    end
  endtask

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.func       = FN_ALLOC;
    req_ch.slot_index = '0;
    req_ch.count      = '0;
    hold_left         = 0;
    send_gap_pct      = 10;
    rcv_stall_pct     = 81;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset registers (capacity 256, nothing taken at reinit).
    issue(FN_ALLOC, '0, '0);                  // first fit from empty map
    issue(FN_ALLOC, '0, '0);
    issue(FN_ALLOC, '0, '0);
    issue(FN_FREE, 8'd1, '0);                 // ok
    issue(FN_FREE, 8'd1, '0);                 // slot already free
    issue(FN_FREE, 8'd255, '0);               // top slot, never taken
    issue(FN_MARK, 8'd250, 9'd6);             // range ends exactly at capacity
    issue(FN_MARK, 8'd255, 9'd2);             // one past capacity
    issue(FN_MARK, 8'd0, 9'd0);               // empty range
    issue(FN_MARK, 8'd17, 9'd511);            // count at field max
    issue(FN_MARK, 8'd0, 9'd256);             // whole map
    issue(FN_ALLOC, '0, '0);                  // map full
    issue(FN_FREE, 8'd255, '0);
    issue(FN_ALLOC, '0, '0);                  // gets the top slot back
    issue(FN_REINIT, 8'd255, 9'd511);

    // Capacity zero: nothing addressable, only the empty range and reinit pass.
    set_regs(0, 0);
    issue(FN_ALLOC, '0, '0);
    issue(FN_FREE, 8'd0, '0);
    issue(FN_MARK, 8'd0, 9'd0);
    issue(FN_MARK, 8'd0, 9'd1);
    issue(FN_REINIT, '0, '0);

    // Capacity and initially-taken past the built size: clamp to 256.
    set_regs(511, 511);
    issue(FN_REINIT, '0, '0);
    issue(FN_ALLOC, '0, '0);
    issue(FN_FREE, 8'd128, '0);
    issue(FN_ALLOC, '0, '0);

    // Lowered capacity: upper slots keep their bits but are out of reach.
    set_regs(10, 4);
    issue(FN_FREE, 8'd200, '0);
    issue(FN_REINIT, '0, '0);
    issue(FN_MARK, 8'd8, 9'd3);
    issue(FN_ALLOC, '0, '0);

    // Random phases: sender mostly busy / receiver mostly stalled, then the
    // reverse, then both at full rate with the long hold-off.
    run_segment(190, 16, 5, 1'b0);
    run_segment(190, 511, 100, 1'b0);
    send_gap_pct  = 81;
    rcv_stall_pct = 10;
    run_segment(190, 40, 0, 1'b0);
    run_segment(190, 1, 1, 1'b0);
    send_gap_pct  = 0;
    rcv_stall_pct = 0;
    run_segment(190, 256, 256, 1'b1);
    run_segment(190, 23, 511, 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
